### design/uart_rx_tx_ring_buffers_assert.svh
// assertion macros for the uart ring buffer block
// needs a clock named clock and an active high reset named reset in scope
`ifndef UART_RX_TX_RING_BUFFERS_ASSERT_SVH
`define UART_RX_TX_RING_BUFFERS_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define URTB_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("urtb assertion failed");

// next-cycle implication
`define URTB_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("urtb assertion failed");

`else

`define URTB_ASSERT_IMP(label, ante, cons)
`define URTB_ASSERT_NXT(label, ante, cons)

`endif

`endif

### design/urtb_pkg.sv
// shared types and constants for the uart receive/transmit ring buffers
// no dependencies
package urtb_pkg;

   // ring sizes
   localparam int RX_DEPTH = 512;
   localparam int TX_DEPTH = 512;

   // pointer and count widths
   localparam int RX_PTR_W = $clog2(RX_DEPTH);
   localparam int TX_PTR_W = $clog2(TX_DEPTH);
   localparam int RX_CNT_W = $clog2(RX_DEPTH);
   localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);

   // field widths
   localparam int CMD_W      = 2;
   localparam int BYTE_W     = 8;
   localparam int RX_FILL_W  = 9;
   localparam int TX_FILL_W  = 10;

   // event codes
   typedef enum logic [CMD_W-1:0] {
      CMD_RX_BYTE  = 2'd0,
      CMD_SW_READ  = 2'd1,
      CMD_SW_WRITE = 2'd2,
      CMD_TX_READY = 2'd3
   } cmd_type;

   // control sequence
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

endpackage

### design/urtb_ram.sv
// generic single-port-write, single-port-read byte store, registered read
// no dependencies
module urtb_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/uart_rx_tx_ring_buffers.sv
// uart receive and transmit ring buffers, one event word in, one status word out
// the event word is registered when accepted, the result word once the output is free
// one event word at a time: the registered read of the byte stores comes ahead of the
//   read-modify-write of pointers, counts and store entries
// reset: synchronous, clears pointers, counts, overflow flag and marks the
//   transmitter idle; store contents are not cleared and there is no clearing pass
module uart_rx_tx_ring_buffers (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_data_byte,
   input  logic        req_line_error,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_read_valid,
   output logic [7:0]  rsp_send_byte,
   output logic        rsp_send_valid,
   output logic        rsp_write_refused,
   output logic        rsp_overflow_flag,
   output logic [8:0]  rsp_rx_fill,
   output logic [9:0]  rsp_tx_fill
);

`include "uart_rx_tx_ring_buffers_assert.svh"

   localparam int RXP = urtb_pkg::RX_PTR_W;
   localparam int TXP = urtb_pkg::TX_PTR_W;
   localparam int RXC = urtb_pkg::RX_CNT_W;
   localparam int TXC = urtb_pkg::TX_CNT_W;
   localparam int BW  = urtb_pkg::BYTE_W;

   // control state
   urtb_pkg::state_type state_ff, state_in;
   logic [RXP-1:0] rx_wr_ptr_ff, rx_wr_ptr_in;
   logic [RXP-1:0] rx_rd_ptr_ff, rx_rd_ptr_in;
   logic [RXC-1:0] rx_cnt_ff, rx_cnt_in;
   logic           rx_ovf_ff, rx_ovf_in;
   logic [TXP-1:0] tx_wr_ptr_ff, tx_wr_ptr_in;
   logic [TXP-1:0] tx_rd_ptr_ff, tx_rd_ptr_in;
   logic [TXC-1:0] tx_cnt_ff, tx_cnt_in;
   logic           tx_idle_ff, tx_idle_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // captured event word
   urtb_pkg::cmd_type cmd_ff;
   logic [BW-1:0]     data_ff;
   logic              err_ff;

   // result word
   logic [BW-1:0] rd_byte_ff, rd_byte_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [BW-1:0] sd_byte_ff, sd_byte_in;
   logic          sd_valid_ff, sd_valid_in;
   logic          refused_ff, refused_in;

   // sequencing strobes
   logic accept;
   logic fire;
   logic exec_stall;
   logic rx_we, tx_we;
   logic [BW-1:0] rx_q, tx_q;
   logic [RXC:0]  rx_cnt_inc;

   // store instances
   urtb_ram #(.DEPTH(urtb_pkg::RX_DEPTH), .WIDTH(BW)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_we),
      .wr_addr (rx_wr_ptr_ff),
      .wr_data (data_ff),
      .rd_en   (accept),
      .rd_addr (rx_rd_ptr_ff),
      .rd_data (rx_q)
   );

   urtb_ram #(.DEPTH(urtb_pkg::TX_DEPTH), .WIDTH(BW)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_we),
      .wr_addr (tx_wr_ptr_ff),
      .wr_data (data_ff),
      .rd_en   (accept),
      .rd_addr (tx_rd_ptr_ff),
      .rd_data (tx_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         urtb_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = urtb_pkg::ST_EXEC;
            end
         end
         urtb_pkg::ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = urtb_pkg::ST_IDLE;
            end
         end
         default: state_in = urtb_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      fire      = 1'b0;
      case (state_ff)
         urtb_pkg::ST_IDLE: req_ready = 1'b1;
         urtb_pkg::ST_EXEC: fire = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            fire      = 1'b0;
         end
      endcase
   end

   assign accept     = req_valid && req_ready;
   assign exec_stall = (state_ff == urtb_pkg::ST_EXEC) && rsp_valid_ff && !rsp_ready;
   assign rx_cnt_inc = {1'b0, rx_cnt_ff} + (RXC+1)'(1);

   // read-modify-write of the ring state
   always_comb begin
      rx_wr_ptr_in = rx_wr_ptr_ff;
      rx_rd_ptr_in = rx_rd_ptr_ff;
      rx_cnt_in    = rx_cnt_ff;
      rx_ovf_in    = rx_ovf_ff;
      tx_wr_ptr_in = tx_wr_ptr_ff;
      tx_rd_ptr_in = tx_rd_ptr_ff;
      tx_cnt_in    = tx_cnt_ff;
      tx_idle_in   = tx_idle_ff;
      rd_byte_in   = '0;
      rd_valid_in  = 1'b0;
      sd_byte_in   = '0;
      sd_valid_in  = 1'b0;
      refused_in   = 1'b0;
      rx_we        = 1'b0;
      tx_we        = 1'b0;
      case (cmd_ff)
         urtb_pkg::CMD_RX_BYTE: begin
            if (!err_ff) begin
               rx_we = fire;
               rx_wr_ptr_in = (rx_wr_ptr_ff == RXP'(urtb_pkg::RX_DEPTH - 1)) ?
                              '0 : rx_wr_ptr_ff + RXP'(1);
               // full ring wraps the count to zero and flags overflow
               if (rx_cnt_inc == (RXC+1)'(urtb_pkg::RX_DEPTH)) begin
                  rx_cnt_in = '0;
                  rx_ovf_in = 1'b1;
               end else begin
                  rx_cnt_in = rx_cnt_inc[RXC-1:0];
               end
            end
         end
         urtb_pkg::CMD_SW_READ: begin
            if (rx_cnt_ff != '0) begin
               rd_byte_in   = rx_q;
               rd_valid_in  = 1'b1;
               rx_rd_ptr_in = (rx_rd_ptr_ff == RXP'(urtb_pkg::RX_DEPTH - 1)) ?
                              '0 : rx_rd_ptr_ff + RXP'(1);
               rx_cnt_in    = rx_cnt_ff - RXC'(1);
            end
         end
         urtb_pkg::CMD_SW_WRITE: begin
            if (tx_cnt_ff >= TXC'(urtb_pkg::TX_DEPTH)) begin
               refused_in = 1'b1;
            end else if (tx_cnt_ff == '0 && tx_idle_ff) begin
               // empty ring and idle transmitter: straight out
               sd_byte_in  = data_ff;
               sd_valid_in = 1'b1;
               tx_idle_in  = 1'b0;
            end else begin
               tx_we = fire;
               tx_wr_ptr_in = (tx_wr_ptr_ff == TXP'(urtb_pkg::TX_DEPTH - 1)) ?
                              '0 : tx_wr_ptr_ff + TXP'(1);
               tx_cnt_in    = tx_cnt_ff + TXC'(1);
            end
         end
         urtb_pkg::CMD_TX_READY: begin
            if (tx_cnt_ff != '0) begin
               sd_byte_in   = tx_q;
               sd_valid_in  = 1'b1;
               tx_rd_ptr_in = (tx_rd_ptr_ff == TXP'(urtb_pkg::TX_DEPTH - 1)) ?
                              '0 : tx_rd_ptr_ff + TXP'(1);
               tx_cnt_in    = tx_cnt_ff - TXC'(1);
               tx_idle_in   = 1'b0;
            end else begin
               tx_idle_in = 1'b1;
            end
         end
         default: begin
            rx_we = 1'b0;
            tx_we = 1'b0;
         end
      endcase
   end

   // output word valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= urtb_pkg::ST_IDLE;
         rx_wr_ptr_ff <= '0;
         rx_rd_ptr_ff <= '0;
         rx_cnt_ff    <= '0;
         rx_ovf_ff    <= 1'b0;
         tx_wr_ptr_ff <= '0;
         tx_rd_ptr_ff <= '0;
         tx_cnt_ff    <= '0;
         tx_idle_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            rx_wr_ptr_ff <= rx_wr_ptr_in;
            rx_rd_ptr_ff <= rx_rd_ptr_in;
            rx_cnt_ff    <= rx_cnt_in;
            rx_ovf_ff    <= rx_ovf_in;
            tx_wr_ptr_ff <= tx_wr_ptr_in;
            tx_rd_ptr_ff <= tx_rd_ptr_in;
            tx_cnt_ff    <= tx_cnt_in;
            tx_idle_ff   <= tx_idle_in;
         end
      end
   end

   // event word capture
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= urtb_pkg::cmd_type'(req_cmd);
         data_ff <= req_data_byte;
         err_ff  <= req_line_error;
      end
   end

   // result word registers
   always_ff @(posedge clock) begin
      if (fire) begin
         rd_byte_ff  <= rd_byte_in;
         rd_valid_ff <= rd_valid_in;
         sd_byte_ff  <= sd_byte_in;
         sd_valid_ff <= sd_valid_in;
         refused_ff  <= refused_in;
      end
   end

   // status fields follow the committed state
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_byte     = rd_byte_ff;
   assign rsp_read_valid    = rd_valid_ff;
   assign rsp_send_byte     = sd_byte_ff;
   assign rsp_send_valid    = sd_valid_ff;
   assign rsp_write_refused = refused_ff;
   assign rsp_overflow_flag = rx_ovf_ff;
   assign rsp_rx_fill       = urtb_pkg::RX_FILL_W'(rx_cnt_ff);
   assign rsp_tx_fill       = urtb_pkg::TX_FILL_W'(tx_cnt_ff);

   // checks
   `URTB_ASSERT_NXT(a_accept_to_exec, accept, state_ff == urtb_pkg::ST_EXEC)
   `URTB_ASSERT_NXT(a_exec_holds, exec_stall, state_ff == urtb_pkg::ST_EXEC)
   `URTB_ASSERT_IMP(a_queue_means_busy, tx_cnt_ff != '0, !tx_idle_ff)
   `URTB_ASSERT_IMP(a_tx_cnt_bound, 1'b1, tx_cnt_ff <= TXC'(urtb_pkg::TX_DEPTH))
   `URTB_ASSERT_IMP(a_read_send_excl, rsp_valid_ff, !(rd_valid_ff && sd_valid_ff))

endmodule

### test/uart_rx_tx_ring_buffers_checker.sv
// status word checker for the uart receive/transmit ring buffers
// watches both channels, keeps its own copy of the two rings and compares each status word
// depends on urtb_pkg for the event codes, ring sizes and field widths
module urtb_status_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [urtb_pkg::CMD_W-1:0]     req_cmd,
   input  logic [urtb_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic                           req_line_error,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [urtb_pkg::BYTE_W-1:0]    rsp_read_byte,
   input  logic                           rsp_read_valid,
   input  logic [urtb_pkg::BYTE_W-1:0]    rsp_send_byte,
   input  logic                           rsp_send_valid,
   input  logic                           rsp_write_refused,
   input  logic                           rsp_overflow_flag,
   input  logic [urtb_pkg::RX_FILL_W-1:0] rsp_rx_fill,
   input  logic [urtb_pkg::TX_FILL_W-1:0] rsp_tx_fill,
   output int                             mismatches,
   output int                             words_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   // one status word as the block reports it
   typedef struct {
      logic [urtb_pkg::BYTE_W-1:0]    read_byte;
      logic                           read_valid;
      logic [urtb_pkg::BYTE_W-1:0]    send_byte;
      logic                           send_valid;
      logic                           write_refused;
      logic                           overflow_flag;
      logic [urtb_pkg::RX_FILL_W-1:0] rx_fill;
      logic [urtb_pkg::TX_FILL_W-1:0] tx_fill;
   } ring_status_type;

   ring_status_type status_owed [$];

   // receive ring copy
   logic [urtb_pkg::BYTE_W-1:0] rx_bytes [urtb_pkg::RX_DEPTH];
   int                          rx_wr, rx_rd, rx_level;
   logic                        rx_lost;

   // transmit ring copy
   logic [urtb_pkg::BYTE_W-1:0] tx_bytes [urtb_pkg::TX_DEPTH];
   int                          tx_wr, tx_rd, tx_level;
   logic                        tx_idle;

   int fail_total = 0;
   int word_index = 0;

   assign mismatches = fail_total;

   // one event applied to the ring copies, giving the status word it should produce
   function automatic ring_status_type apply_event(input urtb_pkg::cmd_type cmd,
                                                   input logic [urtb_pkg::BYTE_W-1:0] data,
                                                   input logic line_err);
      ring_status_type st;
      st = '{default: '0};
      case (cmd)
         urtb_pkg::CMD_RX_BYTE: begin
            // errored bytes are dropped without trace
            if (!line_err) begin
               rx_bytes[rx_wr] = data;
               rx_wr = (rx_wr + 1) % urtb_pkg::RX_DEPTH;
               rx_level++;
               // a full ring wraps its count to zero and latches the overflow flag
               if (rx_level >= urtb_pkg::RX_DEPTH) begin
                  rx_level = 0;
                  rx_lost = 1'b1;
               end
            end
         end
         urtb_pkg::CMD_SW_READ: begin
            if (rx_level != 0) begin
               st.read_byte = rx_bytes[rx_rd];
               st.read_valid = 1'b1;
               rx_rd = (rx_rd + 1) % urtb_pkg::RX_DEPTH;
               rx_level--;
            end
         end
         urtb_pkg::CMD_SW_WRITE: begin
            if (tx_level >= urtb_pkg::TX_DEPTH) begin
               st.write_refused = 1'b1;
            end else if (tx_level == 0 && tx_idle) begin
               // idle transmitter and empty ring: byte goes straight out
               st.send_byte = data;
               st.send_valid = 1'b1;
               tx_idle = 1'b0;
            end else begin
               tx_bytes[tx_wr] = data;
               tx_wr = (tx_wr + 1) % urtb_pkg::TX_DEPTH;
               tx_level++;
            end
         end
         default: begin
            if (tx_level != 0) begin
               st.send_byte = tx_bytes[tx_rd];
               st.send_valid = 1'b1;
               tx_rd = (tx_rd + 1) % urtb_pkg::TX_DEPTH;
               tx_level--;
               tx_idle = 1'b0;
            end else begin
               tx_idle = 1'b1;
            end
         end
      endcase
      st.overflow_flag = rx_lost;
      st.rx_fill = urtb_pkg::RX_FILL_W'(rx_level);
      st.tx_fill = urtb_pkg::TX_FILL_W'(tx_level);
      return st;
   endfunction

   // one line per mismatch
   task automatic flag_mismatch(input string msg);
      $display("mismatch: %s", msg);
      fail_total++;
   endtask

   task automatic check_field(input string field_name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         flag_mismatch($sformatf("status word %0d %s: got %0h, expected %0h",
                                 word_index, field_name, got, want));
   endtask

   // predict on accepted event words, compare on accepted status words
   always @(posedge clock) begin
      ring_status_type want;
      if (reset) begin
         rx_wr = 0;
         rx_rd = 0;
         rx_level = 0;
         rx_lost = 1'b0;
         tx_wr = 0;
         tx_rd = 0;
         tx_level = 0;
         tx_idle = 1'b1;
         status_owed.delete();
      end else begin
         if (req_valid && req_ready)
            status_owed.push_back(apply_event(urtb_pkg::cmd_type'(req_cmd), req_data_byte,
                                              req_line_error));
         if (rsp_valid && rsp_ready) begin
            if (status_owed.size() == 0) begin
               flag_mismatch($sformatf("status word %0d arrived with nothing owed",
                                       word_index));
            end else begin
               want = status_owed.pop_front();
               check_field("read_byte", 32'(rsp_read_byte), 32'(want.read_byte));
               check_field("read_valid", 32'(rsp_read_valid), 32'(want.read_valid));
               check_field("send_byte", 32'(rsp_send_byte), 32'(want.send_byte));
               check_field("send_valid", 32'(rsp_send_valid), 32'(want.send_valid));
               check_field("write_refused", 32'(rsp_write_refused),
                           32'(want.write_refused));
               check_field("overflow_flag", 32'(rsp_overflow_flag),
                           32'(want.overflow_flag));
               check_field("rx_fill", 32'(rsp_rx_fill), 32'(want.rx_fill));
               check_field("tx_fill", 32'(rsp_tx_fill), 32'(want.tx_fill));
            end
            word_index++;
         end
      end
      words_owed <= status_owed.size();
   end

endmodule

### test/uart_rx_tx_ring_buffers_tb.sv
// testbench top for the uart receive/transmit ring buffers: clock, reset, stimulus, verdict
// depends on urtb_pkg, the block uart_rx_tx_ring_buffers and urtb_status_checker
module uart_rx_tx_ring_buffers_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_WORDS = 400;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [urtb_pkg::CMD_W-1:0]     req_cmd = '0;
   logic [urtb_pkg::BYTE_W-1:0]    req_data_byte = '0;
   logic                           req_line_error = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [urtb_pkg::BYTE_W-1:0]    rsp_read_byte;
   logic                           rsp_read_valid;
   logic [urtb_pkg::BYTE_W-1:0]    rsp_send_byte;
   logic                           rsp_send_valid;
   logic                           rsp_write_refused;
   logic                           rsp_overflow_flag;
   logic [urtb_pkg::RX_FILL_W-1:0] rsp_rx_fill;
   logic [urtb_pkg::TX_FILL_W-1:0] rsp_tx_fill;

   int mismatches;
   int words_owed;

   // idle percentages for the sending and receiving sides
   int send_gap_pct = 10;
   int recv_gap_pct = 47;
   int counted_words = 0;

   uart_rx_tx_ring_buffers dut (.*);

   urtb_status_checker checker_i (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // status side: ready dropped at random
   initial begin
      forever begin
         @(posedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   // one event word, with random idle cycles ahead of it
   task automatic send_event(input urtb_pkg::cmd_type cmd,
                             input logic [urtb_pkg::BYTE_W-1:0] data,
                             input logic line_err);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_data_byte <= data;
      req_line_error <= line_err;
      do @(posedge clock); while (!req_ready);
      // dropped line bytes do not count as work
      if (!(cmd == urtb_pkg::CMD_RX_BYTE && line_err)) counted_words++;
   endtask

   // a run of one event kind with random bytes
   task automatic send_burst(input urtb_pkg::cmd_type cmd, input int n, input int err_pct);
      repeat (n) send_event(cmd, 8'($urandom_range(255)), $urandom_range(99) < err_pct);
   endtask

   // mixed bursts of each kind plus fully random words
   task automatic run_random(input int words);
      int goal;
      int n;
      goal = counted_words + words;
      while (counted_words < goal) begin
         n = $urandom_range(12, 1);
         case ($urandom_range(9))
            0, 1, 2: send_burst(urtb_pkg::CMD_RX_BYTE, n, 12);
            3, 4:    send_burst(urtb_pkg::CMD_SW_READ, n, 50);
            5, 6:    send_burst(urtb_pkg::CMD_SW_WRITE, n, 50);
            7:       send_burst(urtb_pkg::CMD_TX_READY, n, 50);
            default: repeat (n) send_event(urtb_pkg::cmd_type'($urandom_range(3)),
                                           8'($urandom_range(255)),
                                           1'($urandom_range(1)));
         endcase
      end
   endtask

   // watchdog on cycles with no word moving on either channel
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("** uart_rx_tx_ring_buffers: FAILED **");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty rings: read with nothing stored, ready with nothing queued
      send_event(urtb_pkg::CMD_SW_READ, 8'hFF, 1'b1);
      send_event(urtb_pkg::CMD_TX_READY, 8'hFF, 1'b0);
      // receive extremes, then two errored bytes that must vanish
      send_event(urtb_pkg::CMD_RX_BYTE, 8'h00, 1'b0);
      send_event(urtb_pkg::CMD_RX_BYTE, 8'hFF, 1'b0);
      send_event(urtb_pkg::CMD_RX_BYTE, 8'hA5, 1'b1);
      send_event(urtb_pkg::CMD_RX_BYTE, 8'h00, 1'b1);
      send_event(urtb_pkg::CMD_SW_READ, 8'h00, 1'b0);
      send_event(urtb_pkg::CMD_SW_READ, 8'h00, 1'b0);
      send_event(urtb_pkg::CMD_SW_READ, 8'h00, 1'b0);
      // direct send, then queued writes behind a busy transmitter
      send_event(urtb_pkg::CMD_SW_WRITE, 8'hFF, 1'b0);
      send_event(urtb_pkg::CMD_SW_WRITE, 8'h00, 1'b0);
      send_event(urtb_pkg::CMD_SW_WRITE, 8'h5A, 1'b1);
      send_event(urtb_pkg::CMD_TX_READY, 8'h00, 1'b0);
      send_event(urtb_pkg::CMD_TX_READY, 8'h00, 1'b0);
      send_event(urtb_pkg::CMD_TX_READY, 8'h00, 1'b0);
      send_event(urtb_pkg::CMD_SW_WRITE, 8'h81, 1'b0);
      send_event(urtb_pkg::CMD_TX_READY, 8'h00, 1'b0);
      send_event(urtb_pkg::CMD_TX_READY, 8'h00, 1'b0);

      // first phase, the sender side idles less than the receiver
      run_random(RANDOM_WORDS / 3);

      // second phase, the other way round
      send_gap_pct = 47;
      recv_gap_pct = 10;
      run_random(RANDOM_WORDS / 3);

      // last phase with no idling on either side
      send_gap_pct = 0;
      recv_gap_pct = 0;
      run_random(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));
      req_valid <= 1'b0;

      // drain, then a short tail for stray words
      do @(posedge clock); while (words_owed != 0);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && words_owed == 0)
         $display("** uart_rx_tx_ring_buffers: PASSED **");
      else
         $display("** uart_rx_tx_ring_buffers: FAILED **");
      $finish;
   end

endmodule
